/* rtl/gsm_pkg.sv */
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared constants and types of the gradient sharpness measure block.
// ----------------------------------------------------------------------------
package gsm_pkg;

   // field and register widths
   localparam int CFG_BITS        = 13;
   localparam int PIXEL_PORT_BITS = 16;
   localparam int RESULT_BITS     = 32;
   localparam int FRAC_BITS       = 16;

   // frame height limit and row counter width
   localparam int HEIGHT_LIMIT    = 4096;
   localparam int ROW_COUNT_BITS  = $clog2(HEIGHT_LIMIT);

   // defaults for the top level parameters
   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_PIXEL_BITS = 16;

   // register map
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [CFG_BITS-1:0]       CFG_RESET_VALUE  = 13'd1024;

   // divider status seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
   } gsm_div_status_type;

endpackage

/* rtl/gradient_sharpness_measure_core.sv */
// Result path: the last pixel of a frame passes the stage 1 and stage 2 registers,
//   the divider load, the overflow check, 32 divide steps and the output register.
// Throughput: one pixel per cycle; the last pixel of a frame waits while the previous
//   frame end is still in the pipeline, in the bit-serial divider or not yet handed on.
// Reset: synchronous, clears counters, accumulator, left pixel and handshakes;
//   width and height return to 1024; the line store is not cleared.
// ----------------------------------------------------------------------------
// gradient_sharpness_measure_core
// Absolute gradient sum focus measure over a raster pixel stream, with the
// previous row in a single-port line store and a serial divider per frame.
// ----------------------------------------------------------------------------
module gradient_sharpness_measure_core
   import gsm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   // pixel input
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PIXEL_PORT_BITS-1:0] req_pixel,
   // result output
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [RESULT_BITS-1:0]     rsp_sharpness,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CFG_BITS-1:0]        csr_data
);

   localparam int PixW   = (PIXEL_BITS < PIXEL_PORT_BITS) ? PIXEL_BITS : PIXEL_PORT_BITS;
   localparam int ColW   = $clog2(MAX_WIDTH);
   localparam int WidW   = ($clog2(MAX_WIDTH + 1) < CFG_BITS) ? $clog2(MAX_WIDTH + 1)
                                                               : CFG_BITS;
   localparam int HgtW   = CFG_BITS;
   localparam int RowW   = ROW_COUNT_BITS;
   localparam int DivW   = WidW + HgtW + 1;
   localparam int SumW   = PixW + WidW + HgtW;
   localparam int CmpW   = (ColW + 1 > WidW) ? ColW + 1 : WidW;

   // configuration
   logic [CFG_BITS-1:0]  width_cfg_ff;
   logic [CFG_BITS-1:0]  height_cfg_ff;

   // front end state
   logic [ColW-1:0]      col_ff;
   logic [ColW-1:0]      col_in;
   logic [RowW-1:0]      row_ff;
   logic [RowW-1:0]      row_in;
   logic [PixW-1:0]      left_ff;
   logic [PixW-1:0]      row_mem [MAX_WIDTH];

   logic [PixW-1:0]      pixel;
   logic [WidW-1:0]      width_eff;
   logic [HgtW-1:0]      height_eff;
   logic [ColW:0]        col_next;
   logic [RowW:0]        row_next;
   logic                 col_end;
   logic                 row_end;
   logic                 frame_end;
   logic                 end_pending;
   logic                 req_fire;

   // stage 1
   logic                 s1_valid_ff;
   logic                 s1_last_ff;
   logic                 s1_active_ff;
   logic [PixW-1:0]      s1_pixel_ff;
   logic [PixW-1:0]      s1_left_ff;
   logic [PixW-1:0]      s1_above_ff;
   logic [WidW-1:0]      s1_width_ff;
   logic [HgtW-1:0]      s1_height_ff;
   logic [PixW-1:0]      diff_left;
   logic [PixW-1:0]      diff_above;
   logic [PixW:0]        s1_grad;
   logic [WidW+HgtW-1:0] s1_area;

   // stage 2
   logic                 s2_valid_ff;
   logic                 s2_last_ff;
   logic [PixW:0]        s2_grad_ff;
   logic [DivW-1:0]      s2_divisor_ff;
   logic [SumW-1:0]      acc_ff;
   logic [SumW-1:0]      acc_in;
   logic [SumW-1:0]      frame_sum;

   // divider and output
   gsm_div_status_type     div_status;
   logic [RESULT_BITS-1:0] div_quotient;
   logic                   div_start;
   logic                   div_ack;
   logic                   rsp_valid_ff;
   logic [RESULT_BITS-1:0] rsp_sharpness_ff;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= CFG_RESET_VALUE;
         height_cfg_ff <= CFG_RESET_VALUE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_cfg_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_cfg_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   // clamp frame dimensions to their usable range
   always_comb begin
      if (width_cfg_ff == '0) begin
         width_eff = WidW'(1);
      end else if (32'(width_cfg_ff) > MAX_WIDTH) begin
         width_eff = WidW'(MAX_WIDTH);
      end else begin
         width_eff = WidW'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         height_eff = HgtW'(1);
      end else if (32'(height_cfg_ff) > HEIGHT_LIMIT) begin
         height_eff = HgtW'(HEIGHT_LIMIT);
      end else begin
         height_eff = height_cfg_ff;
      end
   end

   // raster position and end of row / frame
   assign pixel     = req_pixel[PixW-1:0];
   assign col_next  = {1'b0, col_ff} + 1'b1;
   assign row_next  = {1'b0, row_ff} + 1'b1;
   assign col_end   = (CmpW'(col_next) >= CmpW'(width_eff));
   assign row_end   = (HgtW'(row_next) >= height_eff);
   assign frame_end = col_end && row_end;
   assign col_in    = col_end ? '0 : col_next[ColW-1:0];
   assign row_in    = col_end ? (row_end ? '0 : row_next[RowW-1:0]) : row_ff;

   // a frame end may enter only when no other one is in flight
   assign end_pending = (s1_valid_ff && s1_last_ff) || (s2_valid_ff && s2_last_ff)
                        || div_status.busy;
   assign req_ready   = !(frame_end && end_pending);
   assign req_fire    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else if (req_fire) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= pixel;
      end
   end

   // line store: read the pixel above, then replace it with the current one
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_above_ff     <= row_mem[col_ff];
         row_mem[col_ff] <= pixel;
      end
   end

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      if (req_fire) begin
         s1_last_ff   <= frame_end;
         s1_active_ff <= (row_ff != '0) && (col_ff != '0);
         s1_pixel_ff  <= pixel;
         s1_left_ff   <= left_ff;
         s1_width_ff  <= width_eff;
         s1_height_ff <= height_eff;
      end
   end

   // absolute differences to left and above neighbors
   assign diff_left  = (s1_pixel_ff > s1_left_ff)  ? s1_pixel_ff - s1_left_ff
                                                   : s1_left_ff - s1_pixel_ff;
   assign diff_above = (s1_pixel_ff > s1_above_ff) ? s1_pixel_ff - s1_above_ff
                                                   : s1_above_ff - s1_pixel_ff;
   assign s1_grad    = s1_active_ff ? ({1'b0, diff_left} + {1'b0, diff_above}) : '0;

   // full width frame area for the divisor
   assign s1_area    = (WidW+HgtW)'(s1_width_ff) * (WidW+HgtW)'(s1_height_ff);

   // stage 2 capture, including the frame divisor 2*w*h
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_last_ff    <= s1_last_ff;
         s2_grad_ff    <= s1_grad;
         s2_divisor_ff <= {s1_area, 1'b0};
      end
   end

   // accumulator, cleared when a frame hands its sum to the divider
   assign frame_sum = acc_ff + SumW'(s2_grad_ff);
   assign div_start = s2_valid_ff && s2_last_ff;
   assign acc_in    = div_start ? '0 : frame_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   gsm_divider #(
      .SUM_BITS (SumW),
      .DIV_BITS (DivW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (frame_sum),
      .divisor  (s2_divisor_ff),
      .ack      (div_ack),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // output register
   assign div_ack = div_status.done && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (div_ack) begin
         rsp_sharpness_ff <= div_quotient;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sharpness = rsp_sharpness_ff;

`ifndef ASSERT_OFF
   // at most one frame end in the pipeline or divider at a time
   a_one_frame_end: assert property (@(posedge clock) disable iff (reset)
      $countones({s1_valid_ff && s1_last_ff, s2_valid_ff && s2_last_ff,
                  div_status.busy}) <= 1)
      else $error("more than one frame end in flight");

   // a new result only comes from a finished divide
   a_rsp_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(div_status.done))
      else $error("result raised without a finished divide");

   // the accumulator starts each frame from zero
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (acc_ff == '0))
      else $error("accumulator not cleared at frame end");
`endif

endmodule

/* rtl/gsm_divider.sv */
// ----------------------------------------------------------------------------
// gsm_divider
// Restoring divider for the end-of-frame result: floor(sum * 2^16 / divisor),
// saturated to all ones, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsm_divider
   import gsm_pkg::*;
#(
   parameter int SUM_BITS = 42,
   parameter int DIV_BITS = 27
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SUM_BITS-1:0]     sum,
   input  logic [DIV_BITS-1:0]     divisor,
   input  logic                    ack,
   output gsm_div_status_type      status,
   output logic [RESULT_BITS-1:0]  quotient
);

   localparam int HiBits  = SUM_BITS - FRAC_BITS;
   localparam int CmpBits = (HiBits > DIV_BITS) ? HiBits : DIV_BITS;
   localparam int CntBits = $clog2(RESULT_BITS);
   localparam logic [CntBits-1:0] LastStep = CntBits'(RESULT_BITS - 1);

   typedef enum logic [1:0] {DIV_IDLE, DIV_CHECK, DIV_RUN, DIV_DONE} div_state_type;

   div_state_type          state_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [DIV_BITS-1:0]    divisor_ff;
   logic [DIV_BITS-1:0]    rem_ff;
   logic [RESULT_BITS-1:0] quo_ff;
   logic [CntBits-1:0]     step_ff;

   logic [CmpBits-1:0]     sum_hi;
   logic [CmpBits-1:0]     divisor_ext;
   logic                   overflow;
   logic [DIV_BITS:0]      shifted;
   logic [DIV_BITS+1:0]    trial;
   logic                   fits;
   logic [DIV_BITS-1:0]    rem_in;

   // quotient above 32 bits when the integer part exceeds 16 bits
   assign sum_hi      = CmpBits'(sum_ff[SUM_BITS-1:FRAC_BITS]);
   assign divisor_ext = CmpBits'(divisor_ff);
   assign overflow    = (sum_hi >= divisor_ext);

   // one restoring step: next dividend bit comes out of the quotient shifter
   assign shifted = {rem_ff, quo_ff[RESULT_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor_ff};
   assign fits    = ~trial[DIV_BITS+1];
   assign rem_in  = fits ? trial[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         unique case (state_ff)
            DIV_IDLE: begin
               if (start) begin
                  sum_ff     <= sum;
                  divisor_ff <= divisor;
                  state_ff   <= DIV_CHECK;
               end
            end
            DIV_CHECK: begin
               if (overflow) begin
                  quo_ff   <= '1;
                  state_ff <= DIV_DONE;
               end else begin
                  rem_ff   <= DIV_BITS'(sum_ff >> FRAC_BITS);
                  quo_ff   <= {sum_ff[FRAC_BITS-1:0], {(RESULT_BITS-FRAC_BITS){1'b0}}};
                  step_ff  <= '0;
                  state_ff <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               rem_ff  <= rem_in;
               quo_ff  <= {quo_ff[RESULT_BITS-2:0], fits};
               step_ff <= step_ff + 1'b1;
               if (step_ff == LastStep) begin
                  state_ff <= DIV_DONE;
               end
            end
            DIV_DONE: begin
               if (ack) begin
                  state_ff <= DIV_IDLE;
               end
            end
            default: begin
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign status.busy = (state_ff != DIV_IDLE);
   assign status.done = (state_ff == DIV_DONE);
   assign quotient    = quo_ff;

endmodule
